>>> src/pqcrc_pkg.sv
// ----------------------------------------------------------------------------
// pqcrc_pkg: shared definitions for the quad CRC password key block
// Lane count, CRC polynomials, the all-ones start value and the byte-wide
// update step of a reflected CRC-32 register.
// ----------------------------------------------------------------------------
package pqcrc_pkg;

	localparam int unsigned LANES    = 4;
	localparam int unsigned CRC_W    = 32;
	localparam int unsigned BYTE_W   = 8;

	typedef logic [CRC_W-1:0]  crc_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LANES-1:0][CRC_W-1:0] crc_bank_t;

	localparam crc_t CRC_INIT = 32'hFFFF_FFFF;

	// Reflected polynomials: CRC-32, CRC-32C, CRC-32K, CRC-32Q.
	localparam crc_bank_t LANE_POLY = {
		32'hD582_8281,
		32'hEB31_D82E,
		32'h82F6_3B78,
		32'hEDB8_8320
	};

	// One byte through a reflected CRC register, LSB first, unrolled.
	function automatic crc_t crc_byte(input crc_t crc, input crc_t poly, input byte_t data);
		crc_t t;
		t = {{(CRC_W-BYTE_W){1'b0}}, crc[BYTE_W-1:0] ^ data};
		for (int b = 0; b < BYTE_W; b++) begin
			if (t[0]) begin
				t = (t >> 1) ^ poly;
			end else begin
				t = t >> 1;
			end
		end
		crc_byte = (crc >> BYTE_W) ^ t;
	endfunction

endpackage

>>> src/pqcrc_if.sv
// ----------------------------------------------------------------------------
// pqcrc_pwd_if / pqcrc_key_if: channels of the quad CRC password key block
// Valid/ready channels; a transaction completes when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface pqcrc_pwd_if;
	logic       valid;
	logic       ready;
	logic [7:0] password_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, output password_byte, output has_byte,
		output last, input ready);
	modport sink (input valid, input password_byte, input has_byte,
		input last, output ready);
endinterface

interface pqcrc_key_if;
	logic        valid;
	logic        ready;
	logic [31:0] key_word0;
	logic [31:0] key_word1;
	logic [31:0] key_word2;
	logic [31:0] key_word3;

	modport source (output valid, output key_word0, output key_word1,
		output key_word2, output key_word3, input ready);
	modport sink (input valid, input key_word0, input key_word1,
		input key_word2, input key_word3, output ready);
endinterface

>>> src/password_quad_crc_key.sv
// ----------------------------------------------------------------------------
// password_quad_crc_key: 128-bit key from a password byte stream
// Four reflected CRC-32 lanes (CRC-32, CRC-32C, CRC-32K, CRC-32Q) absorb each
// password byte. A transaction with last set emits the four inverted CRCs as
// key words and returns every lane to all ones.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                                 | Transfers
//  --------+-----+-----------------------------------------+----------------
//  pwd     | in  | password_byte[7:0], has_byte, last      | one per byte
//  key     | out | key_word0..key_word3, 32 bits each      | one per last
//
//  A transaction is captured in the input register; when it moves on, the
//  unrolled byte step updates the four CRC lanes and, on last, loads the key
//  register. One transaction per cycle sustained while key is not stalled.
//  The eight-step XOR network of one lane sets the cycle time.
//  Reset sets every lane to all ones and empties both registers.
//  A stalled key register holds the input register; pwd takes a new
//  transaction whenever the input register is empty or moving on.
//
module password_quad_crc_key (
	input  logic          clk,
	input  logic          arst_n,
	pqcrc_pwd_if.sink     pwd,
	pqcrc_key_if.source   key
);
	import pqcrc_pkg::*;

	logic      valid_s1;
	byte_t     byte_s1;
	logic      has_byte_s1;
	logic      last_s1;
	logic      advance;
	crc_bank_t crc_q;
	crc_bank_t crc_next;
	crc_bank_t key_q;
	logic      key_valid_q;

	// The input register moves on when the key register can take a result.
	assign advance   = !key_valid_q || key.ready;
	assign pwd.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pwd.ready) begin
			valid_s1 <= pwd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pwd.ready && pwd.valid) begin
			byte_s1     <= pwd.password_byte;
			has_byte_s1 <= pwd.has_byte;
			last_s1     <= pwd.last;
		end
	end

	// Byte step for every lane, skipped on a bare transaction.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			crc_next[i] = has_byte_s1 ? crc_byte(crc_q[i], LANE_POLY[i], byte_s1)
				: crc_q[i];
		end
	end

	// CRC lanes: a finishing transaction returns them to all ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= {LANES{CRC_INIT}};
		end else if (valid_s1 && advance) begin
			crc_q <= last_s1 ? {LANES{CRC_INIT}} : crc_next;
		end
	end

	// Key register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (advance) begin
			key_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && last_s1) begin
			for (int i = 0; i < LANES; i++) begin
				key_q[i] <= crc_next[i] ^ CRC_INIT;
			end
		end
	end

	assign key.valid     = key_valid_q;
	assign key.key_word0 = key_q[0];
	assign key.key_word1 = key_q[1];
	assign key.key_word2 = key_q[2];
	assign key.key_word3 = key_q[3];

	// A finishing transaction leaves every lane at all ones.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && last_s1) |=> (crc_q == {LANES{CRC_INIT}}))
		else $error("CRC lanes not restarted after key emission");

	// A bare transaction without last leaves the lanes untouched.
	a_bare_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && !has_byte_s1 && !last_s1) |=> $stable(crc_q))
		else $error("bare transaction changed the CRC lanes");

	// A new key appears only from a finishing transaction.
	a_key_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(key_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("key emitted without a finishing transaction");

	// An empty password yields an all-zero key.
	a_empty_key: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && last_s1 && !has_byte_s1
			&& crc_q == {LANES{CRC_INIT}}) |=> (key_q == '0))
		else $error("empty password gave a nonzero key");

endmodule
